// ===== hw/rtl/text_console_writer_unit_defines.svh =====
// Assertion macros shared by the text console writer RTL.
`ifndef TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_UNIT_DEFINES_SVH

// Checked on every clock edge outside reset.
`define TCW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define TCW_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hw/rtl/tcw_pkg.sv =====
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } opcode_t;

  localparam logic [7:0]  CH_NEWLINE = 8'd10;
  localparam logic [7:0]  CH_RETURN  = 8'd13;
  localparam logic [7:0]  CH_SPACE   = 8'd32;
  localparam logic [7:0]  ATTR_RESET = 8'd5;
  localparam logic [15:0] RESET_CELL = {ATTR_RESET, CH_SPACE};

  localparam logic REG_CHAR_ATTR = 1'b0;

  typedef struct packed {
    logic accept;
    logic exec;
    logic scroll;
    logic clr_row;
    logic clr_all;
    logic init;
    logic sweep_rst;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic op_put;
    logic op_clear;
    logic need_scroll;
    logic need_clear;
    logic sweep_row_end;
    logic sweep_scroll_end;
    logic sweep_cell_end;
  } status_t;

endpackage

`default_nettype wire

// ===== hw/rtl/text_console_writer_unit.sv =====
// Top level of the text console writer: register port, controller and datapath.
//
// Requests: drive opcode, char_code, cell_col, cell_row with start high; a
// request is taken at a clock edge where start is high and busy is low.
// Opcode put writes a character at the cursor (newline, carriage return,
// wrap and scroll handled), read returns one cell, clear fills the screen
// with spaces in the current attribute and keeps the cursor.
// Each request yields one result: done is high for exactly one cycle with
// cell_value, cursor_column and cursor_line valid; it cannot be held off.
// Newline, wrap and clear screen also sweep the memory through its single write
// port, one cell per cycle: a newline or wrap clears the new row, on the last row
// after first scrolling the screen up one row, and clear screen fills every cell.
// Busy stays high while a request runs, so the next one is taken only once it is done.
// After reset the memory is swept to spaces in attribute 5 with busy high;
// the register port is live throughout.
// char_attribute sits at byte address 0 of the APB port, reset value 5.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module text_console_writer_unit #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  opcode,
  input  wire logic [7:0]  char_code,
  input  wire logic [6:0]  cell_col,
  input  wire logic [4:0]  cell_row,
  output logic             done,
  output logic [15:0]      cell_value,
  output logic [6:0]       cursor_column,
  output logic [4:0]       cursor_line,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  tcw_pkg::cmd_t    cmd;
  tcw_pkg::status_t status;
  logic [7:0]       char_attribute;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_attribute <= tcw_pkg::ATTR_RESET;
    end else if (psel && penable && pwrite && paddr[2] == tcw_pkg::REG_CHAR_ATTR) begin
      char_attribute <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == tcw_pkg::REG_CHAR_ATTR) ? {24'h000000, char_attribute} : 32'h0;

  tcw_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  tcw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .status         (status),
    .char_attribute (char_attribute),
    .opcode         (opcode),
    .char_code      (char_code),
    .cell_col       (cell_col),
    .cell_row       (cell_row),
    .done           (done),
    .cell_value     (cell_value),
    .cursor_column  (cursor_column),
    .cursor_line    (cursor_line)
  );

  `TCW_ASSERT(a_done_when_idle, done |-> !busy, "result strobe while busy")
  `TCW_ASSERT_ALWAYS(a_reset_clears, rst |=> (!done && busy), "reset left block idle or done")

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_ctrl.sv =====
// Controller state machine of the text console writer.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  input  wire tcw_pkg::status_t status,
  output tcw_pkg::cmd_t        cmd,
  output logic                 busy
);

  typedef enum logic [5:0] {
    S_INIT    = 6'b000001,
    S_IDLE    = 6'b000010,
    S_EXEC    = 6'b000100,
    S_SCROLL  = 6'b001000,
    S_CLR_ROW = 6'b010000,
    S_CLR_ALL = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_INIT: begin
        cmd.init = 1'b1;
        if (status.sweep_cell_end) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (status.op_put && status.need_scroll) begin
          cmd.sweep_rst = 1'b1;
          state_next = S_SCROLL;
        end else if (status.op_put && status.need_clear) begin
          cmd.sweep_rst = 1'b1;
          state_next = S_CLR_ROW;
        end else if (status.op_clear) begin
          cmd.sweep_rst = 1'b1;
          state_next = S_CLR_ALL;
        end else begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_SCROLL: begin
        cmd.scroll = 1'b1;
        if (status.sweep_scroll_end) begin
          cmd.sweep_rst = 1'b1;
          state_next = S_CLR_ROW;
        end
      end
      S_CLR_ROW: begin
        cmd.clr_row = 1'b1;
        if (status.sweep_row_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_CLR_ALL: begin
        cmd.clr_all = 1'b1;
        if (status.sweep_cell_end) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

  `TCW_ASSERT(a_finish_single, cmd.finish |=> !cmd.finish, "finish held over two cycles")
  `TCW_ASSERT(a_accept_to_exec, cmd.accept |=> (state == S_EXEC), "request not executed")
  `TCW_ASSERT(a_scroll_exit, (state == S_SCROLL) |=> (state == S_SCROLL || state == S_CLR_ROW),
    "scroll not followed by row clear")

endmodule

`default_nettype wire

// ===== hw/rtl/tcw_datapath.sv =====
// Datapath of the text console writer: screen memory, cursor and result registers.
`default_nettype none
`include "text_console_writer_unit_defines.svh"

module tcw_datapath #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire tcw_pkg::cmd_t    cmd,
  output tcw_pkg::status_t      status,
  input  wire logic [7:0]       char_attribute,
  input  wire logic [1:0]       opcode,
  input  wire logic [7:0]       char_code,
  input  wire logic [6:0]       cell_col,
  input  wire logic [4:0]       cell_row,
  output logic                  done,
  output logic [15:0]           cell_value,
  output logic [6:0]            cursor_column,
  output logic [4:0]            cursor_line
);

  localparam int CELL_COUNT = COLUMNS * ROWS;
  localparam int ADDR_W     = $clog2(CELL_COUNT);
  localparam int COL_W      = $clog2(COLUMNS);
  localparam int ROW_W      = $clog2(ROWS);
  localparam int IN_W       = 13;
  localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_LAST = ADDR_W'((ROWS - 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] ROW_LAST    = ADDR_W'(COLUMNS - 1);
  localparam logic [ADDR_W-1:0] ROW_STRIDE  = ADDR_W'(COLUMNS);
  localparam logic [COL_W-1:0]  COL_LAST    = COL_W'(COLUMNS - 1);
  localparam logic [ROW_W-1:0]  LINE_LAST   = ROW_W'(ROWS - 1);

  logic [15:0] mem [CELL_COUNT];

  logic [COL_W-1:0]  col, col_next;
  logic [ROW_W-1:0]  row, row_next;
  logic [ADDR_W-1:0] sweep;
  tcw_pkg::opcode_t  op;
  logic [7:0]        ch;
  logic              in_range;
  logic [15:0]       rdata;

  logic [IN_W-1:0]   in_addr_full;
  logic [ADDR_W-1:0] rd_addr, cur_addr, wr_addr;
  logic [15:0]       wr_data;
  logic              wr_en;
  logic              ordinary, newline;

  assign in_addr_full = IN_W'(cell_row) * IN_W'(COLUMNS) + IN_W'(cell_col);
  assign cur_addr     = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  assign rd_addr      = cmd.scroll ? sweep + ROW_STRIDE : in_addr_full[ADDR_W-1:0];

  assign ordinary = (ch != tcw_pkg::CH_NEWLINE) && (ch != tcw_pkg::CH_RETURN);
  assign newline  = (ch == tcw_pkg::CH_NEWLINE) || (ordinary && col == COL_LAST);

  always_comb begin
    status = '0;
    status.op_put           = (op == tcw_pkg::OP_PUT);
    status.op_clear         = (op == tcw_pkg::OP_CLEAR);
    status.need_clear       = newline;
    status.need_scroll      = newline && (row == LINE_LAST);
    status.sweep_row_end    = (sweep == ROW_LAST);
    status.sweep_scroll_end = (sweep == SCROLL_LAST);
    status.sweep_cell_end   = (sweep == LAST_CELL);
  end

  always_comb begin
    col_next = col;
    row_next = row;
    if (cmd.exec && op == tcw_pkg::OP_PUT) begin
      if (newline) begin
        col_next = '0;
        if (row != LINE_LAST) begin
          row_next = row + 1'b1;
        end
      end else if (ch == tcw_pkg::CH_RETURN) begin
        col_next = '0;
      end else begin
        col_next = col + 1'b1;
      end
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = sweep;
    wr_data = {char_attribute, tcw_pkg::CH_SPACE};
    if (cmd.exec) begin
      wr_en   = (op == tcw_pkg::OP_PUT) && ordinary;
      wr_addr = cur_addr;
      wr_data = {char_attribute, ch};
    end else if (cmd.scroll) begin
      wr_en   = (sweep != '0);
      wr_addr = sweep - 1'b1;
      wr_data = rdata;
    end else if (cmd.clr_row) begin
      wr_en   = 1'b1;
      wr_addr = ADDR_W'(row) * ROW_STRIDE + sweep;
    end else if (cmd.clr_all) begin
      wr_en   = 1'b1;
    end else if (cmd.init) begin
      wr_en   = 1'b1;
      wr_data = tcw_pkg::RESET_CELL;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      op       <= tcw_pkg::opcode_t'(opcode);
      ch       <= char_code;
      in_range <= (32'(cell_col) < 32'(COLUMNS)) && (32'(cell_row) < 32'(ROWS));
    end
    if (cmd.finish) begin
      cell_value    <= (op == tcw_pkg::OP_READ && in_range) ? rdata : 16'h0000;
      cursor_column <= 7'(col_next);
      cursor_line   <= 5'(row_next);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col   <= '0;
      row   <= '0;
      sweep <= '0;
      done  <= 1'b0;
    end else begin
      col  <= col_next;
      row  <= row_next;
      done <= cmd.finish;
      if (cmd.sweep_rst) begin
        sweep <= '0;
      end else if (cmd.scroll || cmd.clr_row || cmd.clr_all || cmd.init) begin
        sweep <= sweep + 1'b1;
      end
    end
  end

  `TCW_ASSERT(a_cursor_bounds, (32'(col) < COLUMNS) && (32'(row) < ROWS), "cursor off screen")

endmodule

`default_nettype wire

// ===== bench/console_checker.sv =====
`timescale 1ns / 1ps
// Console writer checker: mirrors the screen and cursor, predicts each result and compares it.
module console_checker #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [6:0]  cell_col,
  input  logic [4:0]  cell_row,
  input  logic        done,
  input  logic [15:0] cell_value,
  input  logic [6:0]  cursor_column,
  input  logic [4:0]  cursor_line,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          mismatches,
  output int          outstanding
);

  localparam logic [2:0] ATTR_ADDR = {tcw_pkg::REG_CHAR_ATTR, 2'b00};

  typedef struct packed {
    logic [15:0] value;
    logic [6:0]  column;
    logic [4:0]  line;
  } console_result_t;

  logic [15:0]     screen [ROWS][COLUMNS];
  logic [7:0]      attr;
  int              col_pos;
  int              row_pos;
  int              errors = 0;
  console_result_t expected_results [$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic void fill_row(int r);
    for (int c = 0; c < COLUMNS; c++) screen[r][c] = {attr, tcw_pkg::CH_SPACE};
  endfunction

  function automatic void put_char(logic [7:0] ch);
    logic next_line;
    next_line = 1'b0;
    if (ch == tcw_pkg::CH_NEWLINE) begin
      col_pos = 0;
      row_pos++;
      next_line = 1'b1;
    end else if (ch == tcw_pkg::CH_RETURN) begin
      col_pos = 0;
    end else begin
      screen[row_pos][col_pos] = {attr, ch};
      col_pos++;
    end
    if (col_pos >= COLUMNS) begin
      col_pos = 0;
      row_pos++;
      next_line = 1'b1;
    end
    if (row_pos >= ROWS) begin
      row_pos = ROWS - 1;
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++) screen[r][c] = screen[r + 1][c];
    end
    if (next_line) fill_row(row_pos);
  endfunction

  function automatic console_result_t apply_request(logic [1:0] op, logic [7:0] ch,
                                                    logic [6:0] col, logic [4:0] row);
    console_result_t res;
    res.value = '0;
    case (op)
      tcw_pkg::OP_PUT: put_char(ch);
      tcw_pkg::OP_READ: begin
        if (col < COLUMNS && row < ROWS) res.value = screen[row][col];
      end
      tcw_pkg::OP_CLEAR: begin
        for (int r = 0; r < ROWS; r++) fill_row(r);
      end
      default: ;
    endcase
    res.column = 7'(col_pos);
    res.line   = 5'(row_pos);
    return res;
  endfunction

  function automatic void check_field(string what, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= 40)
        $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, what, want, got);
    end
  endfunction

  always @(posedge clk) begin
    console_result_t want;
    if (rst) begin
      attr    = tcw_pkg::ATTR_RESET;
      col_pos = 0;
      row_pos = 0;
      for (int r = 0; r < ROWS; r++) fill_row(r);
      expected_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == ATTR_ADDR) attr = pwdata[7:0];
      if (done) begin
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 40)
            $display("%0t: unexpected result, expected none, got value 'h%0h col %0d line %0d",
                     $time, cell_value, cursor_column, cursor_line);
        end else begin
          want = expected_results.pop_front();
          check_field("cell_value", want.value, cell_value);
          check_field("cursor_column", want.column, cursor_column);
          check_field("cursor_line", want.line, cursor_line);
        end
      end
      if (start && !busy)
        expected_results.push_back(apply_request(opcode, char_code, cell_col, cell_row));
    end
    mismatches  <= errors;
    outstanding <= expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
// Console writer testbench top: drives requests and attribute writes, gives the verdict.
module tb;

  localparam int         COLUMNS      = 80;
  localparam int         ROWS         = 25;
  localparam int         RANDOM_ITEMS = 1100;
  localparam int         PHASES       = 8;
  localparam int         IDLE_LIMIT   = 20000;
  localparam logic [1:0] OP_NONE      = 2'd3;
  localparam logic [2:0] ATTR_ADDR    = {tcw_pkg::REG_CHAR_ATTR, 2'b00};

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        start     = 1'b0;
  logic [1:0]  opcode    = '0;
  logic [7:0]  char_code = '0;
  logic [6:0]  cell_col  = '0;
  logic [4:0]  cell_row  = '0;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [2:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;

  wire         busy;
  wire         done;
  wire  [15:0] cell_value;
  wire  [6:0]  cursor_column;
  wire  [4:0]  cursor_line;
  wire  [31:0] prdata;
  wire         pready;

  int mismatches;
  int outstanding;
  int burst_left  = 0;
  int idle_cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  text_console_writer_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .char_code(char_code), .cell_col(cell_col), .cell_row(cell_row),
    .done(done), .cell_value(cell_value), .cursor_column(cursor_column),
    .cursor_line(cursor_line),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready)
  );

  console_checker #(.COLUMNS(COLUMNS), .ROWS(ROWS)) screen_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .char_code(char_code), .cell_col(cell_col), .cell_row(cell_row),
    .done(done), .cell_value(cell_value), .cursor_column(cursor_column),
    .cursor_line(cursor_line),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready), .paddr(paddr),
    .pwdata(pwdata), .mismatches(mismatches), .outstanding(outstanding)
  );

  always @(posedge clk) begin
    if ((start && !busy) || done || (psel && penable && pwrite)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_request(logic [1:0] op, logic [7:0] ch, logic [6:0] col,
                              logic [4:0] row);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                : $urandom_range(1, 30);
    end
    burst_left--;
    opcode    <= op;
    char_code <= ch;
    cell_col  <= col;
    cell_row  <= row;
    start     <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic put_request(logic [7:0] ch);
    send_request(tcw_pkg::OP_PUT, ch, 7'($urandom()), 5'($urandom()));
  endtask

  task automatic read_request(logic [6:0] col, logic [4:0] row);
    send_request(tcw_pkg::OP_READ, 8'($urandom()), col, row);
  endtask

  // stop sending and let every outstanding request finish
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (outstanding != 0 || busy) @(posedge clk);
  endtask

  task automatic write_attr(logic [7:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ATTR_ADDR;
    pwdata  <= {24'($urandom()), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  initial begin
    int items;
    int kind;
    int len;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);

    // directed: reset contents, bounds, plain bytes, CR, newline, unused op, clear
    read_request(7'd0, 5'd0);
    read_request(7'(COLUMNS - 1), 5'(ROWS - 1));
    read_request(7'(COLUMNS), 5'd0);
    read_request(7'd0, 5'(ROWS));
    read_request(7'h7F, 5'h1F);
    put_request(8'h41);
    put_request(8'h00);
    put_request(8'hFF);
    read_request(7'd0, 5'd0);
    read_request(7'd1, 5'd0);
    read_request(7'd2, 5'd0);
    put_request(tcw_pkg::CH_RETURN);
    put_request(8'h42);
    read_request(7'd0, 5'd0);
    put_request(tcw_pkg::CH_NEWLINE);
    read_request(7'd5, 5'd1);
    put_request(8'h43);
    send_request(OP_NONE, 8'hFF, 7'h7F, 5'h1F);
    read_request(7'd0, 5'd1);
    send_request(tcw_pkg::OP_CLEAR, 8'($urandom()), 7'($urandom()), 5'($urandom()));
    read_request(7'd0, 5'd0);
    read_request(7'd0, 5'd1);
    put_request(8'h7E);

    for (int p = 0; p < PHASES; p++) begin
      drain();
      case (p)
        0:       write_attr(8'h00);
        1:       write_attr(8'hFF);
        default: write_attr(8'($urandom()));
      endcase
      items = 0;
      while (items < RANDOM_ITEMS / PHASES) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          // a line of text, sometimes long enough to wrap
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(75, 100) : $urandom_range(0, 12);
          repeat (len)
            put_request(($urandom_range(0, 9) == 0) ? 8'($urandom())
                                                    : 8'($urandom_range(32, 126)));
          items += len;
          case ($urandom_range(0, 19))
            0, 1, 2:                   ;
            3, 4, 5, 6:                put_request(tcw_pkg::CH_RETURN);
            default:                   put_request(tcw_pkg::CH_NEWLINE);
          endcase
          items++;
        end else if (kind < 75) begin
          if ($urandom_range(0, 9) < 7)
            read_request(7'($urandom_range(0, COLUMNS - 1)), 5'($urandom_range(0, ROWS - 1)));
          else
            read_request(7'($urandom()), 5'($urandom()));
          items++;
        end else if (kind < 85) begin
          case ($urandom_range(0, 2))
            0:       put_request(tcw_pkg::CH_NEWLINE);
            1:       put_request(tcw_pkg::CH_RETURN);
            default: put_request(8'($urandom()));
          endcase
          items++;
        end else if (kind < 90) begin
          send_request(tcw_pkg::OP_CLEAR, 8'($urandom()), 7'($urandom()), 5'($urandom()));
          items++;
        end else if (kind < 95) begin
          send_request(OP_NONE, 8'($urandom()), 7'($urandom()), 5'($urandom()));
        end else begin
          case ($urandom_range(0, 4))
            0:       read_request(7'(COLUMNS - 1), 5'(ROWS - 1));
            1:       read_request(7'(COLUMNS), 5'($urandom_range(0, ROWS - 1)));
            2:       read_request(7'($urandom_range(0, COLUMNS - 1)), 5'(ROWS));
            3:       read_request(7'h7F, 5'h1F);
            default: read_request(7'd0, 5'd0);
          endcase
          items++;
        end
      end
    end

    drain();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/tcw_pkg.sv
hw/rtl/tcw_ctrl.sv
hw/rtl/tcw_datapath.sv
hw/rtl/text_console_writer_unit.sv
bench/console_checker.sv
bench/tb.sv
